FILE: rtl/csb_pkg.sv
package csb_pkg;

    localparam int NUM_RESOURCES = 8;
    localparam int QUEUE_DEPTH   = 16;
    localparam int RES_W         = $clog2(NUM_RESOURCES);
    localparam int SLOT_W        = $clog2(QUEUE_DEPTH);
    localparam int WAIT_W        = SLOT_W + 1;
    localparam int ADDR_W        = RES_W + SLOT_W;
    localparam int MEM_DEPTH     = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int COUNT_W       = 9;
    localparam int PID_W         = 8;
    localparam int RIDX_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int INIT_W        = 8;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 9'sd255;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 2'd1;

    localparam logic CMD_WAIT   = 1'b0;
    localparam logic CMD_SIGNAL = 1'b1;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_BLOCKED  = 2'd1,
        ST_EXIT     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic take;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_pending;
    } dp_status_t;

endpackage

FILE: rtl/csb_ctrl.sv
module csb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                rsp_ready,
    input  csb_pkg::dp_status_t stat,
    output csb_pkg::ctrl_cmd_t  cmd
);
    import csb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   can_commit;

    assign can_commit = !stat.out_pending || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        cmd.take    = stat.out_pending && rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.commit = can_commit;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/csb_datapath.sv
module csb_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  csb_pkg::ctrl_cmd_t                     cmd,
    output csb_pkg::dp_status_t                    stat,
    input  logic                                   command,
    input  logic [csb_pkg::RIDX_W-1:0]             resource,
    input  logic [csb_pkg::PID_W-1:0]              process_id,
    input  logic                                   cfg_we,
    input  logic [csb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic                                   rsp_valid,
    output logic [1:0]                             status,
    output logic                                   woken_valid,
    output logic [csb_pkg::PID_W-1:0]              woken_id,
    output logic signed [csb_pkg::COUNT_W-1:0]     count_after
);
    import csb_pkg::*;

    logic [PID_W-1:0] waiter_mem [MEM_DEPTH];

    logic signed [COUNT_W-1:0] count_reg [NUM_RESOURCES];
    logic signed [COUNT_W-1:0] count_next [NUM_RESOURCES];
    logic [SLOT_W-1:0]         head_reg [NUM_RESOURCES];
    logic [SLOT_W-1:0]         head_next [NUM_RESOURCES];
    logic [RIDX_W-1:0]         in_use_reg;
    logic [RIDX_W-1:0]         in_use_next;

    logic                      cmd_reg;
    logic [RIDX_W-1:0]         res_reg;
    logic [PID_W-1:0]          pid_reg;
    logic [PID_W-1:0]          rd_data_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    logic                      woken_valid_reg;
    logic [PID_W-1:0]          woken_id_reg;
    logic signed [COUNT_W-1:0] count_after_reg;

    logic [RES_W-1:0]          rd_res;
    logic [RES_W-1:0]          r;
    logic [RIDX_W-1:0]         limit;
    logic                      known;
    logic signed [COUNT_W-1:0] cnt;
    logic signed [COUNT_W-1:0] cnt_neg;
    logic signed [COUNT_W-1:0] cnt_new;
    logic [WAIT_W-1:0]         waiters;
    logic                      mem_we;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      head_adv;
    status_t                   res_status;
    logic                      res_woken;
    logic [PID_W-1:0]          res_woken_id;
    logic signed [COUNT_W-1:0] res_count;

    assign rd_res = resource[RES_W-1:0];
    assign r      = res_reg[RES_W-1:0];
    assign limit  = (in_use_reg > RIDX_W'(NUM_RESOURCES)) ? RIDX_W'(NUM_RESOURCES) : in_use_reg;
    assign known  = res_reg < limit;
    assign cnt     = count_reg[r];
    assign cnt_neg = -cnt;
    assign waiters = cnt[COUNT_W-1] ? cnt_neg[WAIT_W-1:0] : '0;
    assign wr_addr = {r, head_reg[r] + waiters[SLOT_W-1:0]};

    always_comb
    begin
        res_status   = ST_CONTINUE;
        res_woken    = 1'b0;
        res_woken_id = '0;
        res_count    = cnt;
        cnt_new      = cnt;
        mem_we       = 1'b0;
        head_adv     = 1'b0;
        if (!known)
        begin
            res_status = ST_EXIT;
            res_count  = '0;
        end
        else if (cmd_reg == CMD_WAIT)
        begin
            if (cnt <= 0 && waiters >= WAIT_W'(QUEUE_DEPTH))
            begin
                res_status = ST_FULL;
            end
            else
            begin
                cnt_new = cnt - 9'sd1;
                if (cnt_new < 0)
                begin
                    mem_we     = 1'b1;
                    res_status = ST_BLOCKED;
                end
            end
            res_count = cnt_new;
        end
        else
        begin
            if (cnt < COUNT_MAX)
            begin
                cnt_new = cnt + 9'sd1;
            end
            if (cnt_new <= 0 && waiters != '0)
            begin
                res_woken    = 1'b1;
                res_woken_id = rd_data_reg;
                head_adv     = 1'b1;
            end
            res_count = cnt_new;
        end
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        for (int i = 0; i < NUM_RESOURCES; i++)
        begin
            count_next[i] = count_reg[i];
            head_next[i]  = head_reg[i];
        end
        if (cfg_we && cfg_index == CFG_RES_IN_USE)
        begin
            in_use_next = cfg_data[RIDX_W-1:0];
        end
        if (cfg_we && cfg_index == CFG_INIT_COUNT)
        begin
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                count_next[i] = {1'b0, cfg_data[INIT_W*i +: INIT_W]};
                head_next[i]  = '0;
            end
        end
        else if (cmd.commit && known)
        begin
            count_next[r] = cnt_new;
            if (head_adv)
            begin
                head_next[r] = head_reg[r] + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd.take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= RIDX_W'(NUM_RESOURCES);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                count_reg[i] <= count_next[i];
                head_reg[i]  <= head_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg     <= command;
            res_reg     <= resource;
            pid_reg     <= process_id;
            rd_data_reg <= waiter_mem[{rd_res, head_reg[rd_res]}];
        end
        if (cmd.commit && mem_we)
        begin
            waiter_mem[wr_addr] <= pid_reg;
        end
        if (cmd.commit)
        begin
            status_reg      <= res_status;
            woken_valid_reg <= res_woken;
            woken_id_reg    <= res_woken_id;
            count_after_reg <= res_count;
        end
    end

    assign stat.out_pending = out_valid_reg;
    assign rsp_valid        = out_valid_reg;
    assign status           = status_reg;
    assign woken_valid      = woken_valid_reg;
    assign woken_id         = woken_id_reg;
    assign count_after      = count_after_reg;

endmodule

FILE: rtl/counting_semaphore_bank.sv
// Bank of eight counting semaphores, each with a 16-entry FIFO of blocked
// process ids kept in one shared waiter memory.
// Request channel (req_valid/req_ready): command, resource, process_id.
// Response channel (rsp_valid/rsp_ready): status, woken_valid, woken_id,
// count_after; one response per request, in request order.
// Configuration: cfg_we with cfg_index 0 sets resources_in_use, index 1
// loads all counts from cfg_data bytes and empties every queue. Write only
// while no request is in flight.
// The response is registered: each request passes a capture step (waiter
// memory read of the queue head) and an execute step (count and queue
// update); rsp_valid rises once the execute step commits. A new request
// is taken only after the previous one has executed.
// Reset: counts and queue heads clear to zero, resources_in_use is 8; the
// waiter memory needs no clearing.
// Stall: a response waiting on rsp_ready does not stop the next request
// from being taken; its execute cycle holds until the response is taken.
module counting_semaphore_bank (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic                                   command,
    input  logic [csb_pkg::RIDX_W-1:0]             resource,
    input  logic [csb_pkg::PID_W-1:0]              process_id,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic [1:0]                             status,
    output logic                                   woken_valid,
    output logic [csb_pkg::PID_W-1:0]              woken_id,
    output logic signed [csb_pkg::COUNT_W-1:0]     count_after,
    input  logic                                   cfg_we,
    input  logic [csb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import csb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    csb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (command),
        .resource    (resource),
        .process_id  (process_id),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rsp_valid   (rsp_valid),
        .status      (status),
        .woken_valid (woken_valid),
        .woken_id    (woken_id),
        .count_after (count_after)
    );

endmodule
